// ===== hw/rtl/rodt_pkg.sv =====
// Shared types and constants for the retentive on-delay timer.
// No dependencies; every other file of the block imports this package.
package rodt_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int CNT_W  = $clog2(DATA_W);

  // Register indexes, taken from byte address bit 2.
  localparam logic REG_PRESET = 1'b0;
  localparam logic REG_BASE   = 1'b1;

  localparam logic [DATA_W-1:0] PRESET_RESET = '0;
  localparam logic [DATA_W-1:0] BASE_RESET   = DATA_W'(1);

  typedef struct packed {
    logic [DATA_W-1:0] preset;
    logic [DATA_W-1:0] base;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/plc_retentive_on_delay_timer_core.sv =====
// Retentive on-delay timer core: one scan request in, one result out.
// An enabled scan that finds the timer running divides by time_base in ST_DIV, then
// loads its result in ST_RESULT; other scans go straight to ST_RESULT. No new scan is
// taken until the result is loaded, and ST_RESULT holds while out_valid waits on out_ready.
// Synchronous active-high reset clears the timer flags, start tick, bank and accumulated value, sets time_base to 1.
// Depends on rodt_pkg, rodt_regs and rodt_div.
module plc_retentive_on_delay_timer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rodt_pkg::ADDR_W-1:0] paddr,
  input  logic [rodt_pkg::DATA_W-1:0] pwdata,
  output logic [rodt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        count_in,
  input  logic                        enable_in,
  input  logic [rodt_pkg::DATA_W-1:0] tick_now,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        done_out,
  output logic                        running_out,
  output logic [rodt_pkg::DATA_W-1:0] accumulated_out
);
  import rodt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RESULT} state_t;

  state_t            state;
  cfg_t              cfg;
  div_status_t       div_st;
  logic [DATA_W-1:0] quotient;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] sum_now;
  logic [DATA_W-1:0] value;
  logic              accept;
  logic              div_start;

  logic              running_flag;
  logic              done_flag;
  logic [DATA_W-1:0] start_tick;
  logic [DATA_W-1:0] banked_ticks;
  logic [DATA_W-1:0] accumulated_value;
  logic [DATA_W-1:0] sum_reg;
  logic              count_reg;

  rodt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign base      = (cfg.base == '0) ? DATA_W'(1) : cfg.base;
  assign sum_now   = tick_now - start_tick + banked_ticks;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = accept && enable_in && !done_flag && running_flag;
  assign value     = quotient + DATA_W'(1);

  rodt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_now),
    .divisor  (base),
    .quotient (quotient),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      running_flag      <= 1'b0;
      done_flag         <= 1'b0;
      start_tick        <= '0;
      banked_ticks      <= '0;
      accumulated_value <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= div_start ? ST_DIV : ST_RESULT;
            if (!enable_in) begin
              accumulated_value <= '0;
              done_flag         <= 1'b0;
              running_flag      <= 1'b0;
              banked_ticks      <= '0;
            end else if (!done_flag) begin
              if (running_flag) begin
                sum_reg   <= sum_now;
                count_reg <= count_in;
              end else if (count_in) begin
                start_tick   <= tick_now;
                running_flag <= 1'b1;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_RESULT;
            if (value >= cfg.preset) begin
              accumulated_value <= cfg.preset;
              done_flag         <= 1'b1;
              running_flag      <= 1'b0;
            end else begin
              accumulated_value <= value;
              if (!count_reg) begin
                // Count dropped early: the whole elapsed sum becomes the bank.
                banked_ticks <= sum_reg;
                running_flag <= 1'b0;
              end
            end
          end
        end
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            done_out        <= done_flag;
            running_out     <= running_flag;
            accumulated_out <= accumulated_value;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(done_flag && running_flag))
    else $error("done and running flags set together");

  a_div_to_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_st.done) |=> (state == ST_RESULT))
    else $error("division finished but sequencer did not move on");

  a_disable_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && !enable_in) |=>
      (!done_flag && !running_flag && accumulated_value == '0 && banked_ticks == '0))
    else $error("disabled scan did not clear the timer");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> (state == ST_DIV))
    else $error("divider busy outside the divide state");

endmodule

// ===== hw/rtl/rodt_regs.sv =====
// Configuration registers of the timer behind an APB-style port.
// Depends on rodt_pkg for the register indexes and the cfg_t bundle.
module rodt_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rodt_pkg::ADDR_W-1:0]   paddr,
  input  logic [rodt_pkg::DATA_W-1:0]   pwdata,
  output logic [rodt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output rodt_pkg::cfg_t                cfg
);
  import rodt_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preset <= PRESET_RESET;
      cfg.base   <= BASE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_PRESET: cfg.preset <= pwdata;
        REG_BASE:   cfg.base   <= pwdata;
        default:    cfg.preset <= cfg.preset;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PRESET: prdata = cfg.preset;
      REG_BASE:   prdata = cfg.base;
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/rodt_div.sv =====
// Restoring divider, one quotient bit per cycle, DATA_W quotient bits per division.
// Depends on rodt_pkg for widths and the status bundle.
module rodt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rodt_pkg::DATA_W-1:0] dividend,
  input  logic [rodt_pkg::DATA_W-1:0] divisor,
  output logic [rodt_pkg::DATA_W-1:0] quotient,
  output rodt_pkg::div_status_t       status
);
  import rodt_pkg::*;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   shifted;
  logic              ge;
  logic [DATA_W:0]   diff;

  // The partial remainder always stays below the divisor, so the
  // difference fits back into DATA_W bits.
  assign shifted = {rem, quotient[DATA_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= status.busy && !start && (cnt == CNT_W'(DATA_W - 1));
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= '0;
      end else if (status.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          status.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (status.busy) begin
      quotient <= {quotient[DATA_W-2:0], ge};
      rem      <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for plc_retentive_on_delay_timer_core: drives scan requests and APB writes,
// and checks every result against a cycle-free model of the timer kept in this file.
// Depends on rodt_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
  import rodt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_SCANS    = 180;

  typedef struct packed {
    logic              done;
    logic              running;
    logic [DATA_W-1:0] value;
  } scan_result_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic              count_in;
  logic              enable_in;
  logic [DATA_W-1:0] tick_now;
  logic              out_valid;
  logic              out_ready;
  logic              done_out;
  logic              running_out;
  logic [DATA_W-1:0] accumulated_out;

  // Timer model state and its copy of the registers.
  logic              tm_run;
  logic              tm_done;
  logic [DATA_W-1:0] tm_start;
  logic [DATA_W-1:0] tm_bank;
  logic [DATA_W-1:0] tm_acc;
  logic [DATA_W-1:0] cfg_preset;
  logic [DATA_W-1:0] cfg_base;

  scan_result_t      pending_results[$];
  int                fail_count   = 0;
  int                quiet_cycles = 0;
  int                ready_hold   = 0;
  bit                gaps_on      = 1'b1;
  logic [DATA_W-1:0] tick_clock   = '0;

  plc_retentive_on_delay_timer_core dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .count_in       (count_in),
    .enable_in      (enable_in),
    .tick_now       (tick_now),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .done_out       (done_out),
    .running_out    (running_out),
    .accumulated_out(accumulated_out)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [DATA_W-1:0] elapsed_units(logic [DATA_W-1:0] tick);
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] sum;
    divisor = (cfg_base == '0) ? DATA_W'(1) : cfg_base;
    sum = tick - tm_start + tm_bank;
    return sum / divisor + DATA_W'(1);
  endfunction

  function automatic void timer_scan(logic cnt, logic ena, logic [DATA_W-1:0] tick);
    scan_result_t res;
    if (!ena) begin
      tm_acc  = '0;
      tm_done = 1'b0;
      tm_run  = 1'b0;
      tm_bank = '0;
    end else if (!tm_done) begin
      if (cnt && !tm_run) begin
        tm_start = tick;
        tm_run   = 1'b1;
      end else if (tm_run) begin
        // A dropped count still evaluates once; it banks only if short of preset.
        tm_acc = elapsed_units(tick);
        if (tm_acc >= cfg_preset) begin
          tm_acc  = cfg_preset;
          tm_done = 1'b1;
        end else if (!cnt) begin
          tm_bank = tm_bank + (tick - tm_start);
        end
        tm_run = cnt && !tm_done;
      end
    end
    res.done    = tm_done;
    res.running = tm_run;
    res.value   = tm_acc;
    pending_results.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_scan(input logic cnt, input logic ena, input logic [DATA_W-1:0] tick);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    count_in  <= cnt;
    enable_in <= ena;
    tick_now  <= tick;
    do @(posedge clk); while (!in_ready);
    timer_scan(cnt, ena, tick);
  endtask

  // Registers may only change once the core has returned every result.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PRESET: cfg_preset = val;
      REG_BASE:   cfg_base   = val;
      default:    ;
    endcase
  endtask

  task automatic set_timer(input logic [DATA_W-1:0] preset, input logic [DATA_W-1:0] base);
    settle();
    write_reg(REG_PRESET, preset);
    write_reg(REG_BASE, base);
  endtask

  // Reset values give a zero preset, so the first evaluated scan latches done at 0.
  task automatic test_zero_preset();
    send_scan(1'b0, 1'b1, 32'd5);
    send_scan(1'b1, 1'b1, 32'd7);
    send_scan(1'b1, 1'b1, 32'd9);
    send_scan(1'b0, 1'b0, 32'd0);
  endtask

  task automatic test_bank_and_latch();
    set_timer(32'd5, 32'd1);
    send_scan(1'b1, 1'b1, 32'd100);
    send_scan(1'b1, 1'b1, 32'd102);
    send_scan(1'b0, 1'b1, 32'd103);
    send_scan(1'b1, 1'b1, 32'd200);
    send_scan(1'b1, 1'b1, 32'd201);
    // Done is latched; count must have no effect until enable drops.
    send_scan(1'b0, 1'b1, 32'd300);
    send_scan(1'b1, 1'b1, 32'd400);
    send_scan(1'b1, 1'b0, 32'd400);
    send_scan(1'b1, 1'b1, 32'd0);
    send_scan(1'b0, 1'b1, 32'd10);
    send_scan(1'b0, 1'b0, 32'd0);
  endtask

  task automatic test_wraparound();
    set_timer(32'hFFFF_FFFF, 32'd1);
    send_scan(1'b1, 1'b1, 32'hFFFF_FFF0);
    send_scan(1'b1, 1'b1, 32'h0000_0010);
    send_scan(1'b0, 1'b0, 32'd0);
    send_scan(1'b1, 1'b1, 32'd0);
    send_scan(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_scan(1'b0, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_base_extremes();
    set_timer(32'd3, 32'd0);
    send_scan(1'b1, 1'b1, 32'd0);
    send_scan(1'b1, 1'b1, 32'd2);
    set_timer(32'd2, 32'hFFFF_FFFF);
    send_scan(1'b0, 1'b0, 32'd0);
    send_scan(1'b1, 1'b1, 32'd0);
    send_scan(1'b1, 1'b1, 32'hFFFF_FFFF);
  endtask

  // Mostly well-formed count pulses on an advancing tick, with some noise scans.
  task automatic test_random_scans();
    int                phase;
    int                n;
    int                run_left;
    int                r;
    logic              cur_count;
    logic              cnt;
    logic              ena;
    logic [DATA_W-1:0] preset;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] step_max;
    logic [DATA_W-1:0] tick;
    run_left  = 0;
    cur_count = 1'b0;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       begin preset = '0;              base = 32'd1;                   end
        1:       begin preset = '1;              base = '1;                      end
        2:       begin preset = $urandom_range(1, 16); base = 32'd1;             end
        3:       begin preset = $urandom_range(1, 16); base = $urandom_range(2, 100); end
        4:       begin preset = $urandom_range(2, 8);  base = $urandom() | 32'h0100_0000; end
        5:       begin preset = $urandom();      base = $urandom();              end
        6:       begin preset = $urandom_range(3, 40); base = $urandom_range(1, 7); end
        default: begin preset = '1;              base = 32'd1;                   end
      endcase
      set_timer(preset, base);
      gaps_on = (phase != 6);
      if (phase == 7) tick_clock = 32'hFFFF_FF00;
      step_max = (base == '0) ? DATA_W'(4) :
                 (base > 32'h0FFF_FFFF) ? '1 : base * 4;
      for (n = 0; n < PHASE_SCANS; n++) begin
        if (run_left == 0) begin
          cur_count = ~cur_count;
          run_left  = cur_count ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end
        run_left--;
        r = $urandom_range(99);
        if (r < 10) begin
        end else if (r < 18) begin
          tick_clock = $urandom();
        end else begin
          tick_clock = tick_clock + $urandom_range(0, step_max);
        end
        cnt  = cur_count;
        ena  = ($urandom_range(99) >= 4);
        tick = tick_clock;
        if ($urandom_range(99) < 8) begin
          cnt  = 1'($urandom_range(1));
          ena  = 1'($urandom_range(1));
          tick = $urandom();
        end
        send_scan(cnt, ena, tick);
      end
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (!gaps_on) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(99) < 65) begin
      out_ready  <= 1'b1;
      ready_hold = $urandom_range(0, 7);
    end else begin
      out_ready  <= 1'b0;
      ready_hold = ($urandom_range(99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 39);
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, actual done %0b running %0b value %0h",
                 $time, done_out, running_out, accumulated_out);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("done_out", DATA_W'(want.done), DATA_W'(done_out));
        check_field("running_out", DATA_W'(want.running), DATA_W'(running_out));
        check_field("accumulated_out", want.value, accumulated_out);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    count_in  = 1'b0;
    enable_in = 1'b0;
    tick_now  = '0;
    out_ready = 1'b0;
    tm_run    = 1'b0;
    tm_done   = 1'b0;
    tm_start  = '0;
    tm_bank   = '0;
    tm_acc    = '0;
    cfg_preset = PRESET_RESET;
    cfg_base   = BASE_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_preset();
    test_bank_and_latch();
    test_wraparound();
    test_base_extremes();
    test_random_scans();

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
